@@ sv/baa_pkg.sv @@
// Shared types, constants and the tangent table for the binary-angle atan2 block.
package baa_pkg;

  // Quotient of the smaller over the larger magnitude, scaled by 8192 (0..8192).
  localparam int QUO_W           = 14;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

  // Front end, divider stages, table search and output register.
  localparam int PIPE_DEPTH = DIV_STAGES + 3;

  localparam int TAN_ENTRIES = 33;
  localparam int IDX_W       = 6;
  localparam int ANG_W       = 8;

  // Octant base angles (a full turn wraps to zero).
  localparam logic [ANG_W-1:0] ANG_ZERO          = 8'h00;
  localparam logic [ANG_W-1:0] ANG_QUARTER       = 8'h40;
  localparam logic [ANG_W-1:0] ANG_HALF          = 8'h80;
  localparam logic [ANG_W-1:0] ANG_THREE_QUARTER = 8'hC0;

  typedef logic [QUO_W-1:0] tan_t;

  // tan(i * pi/128) scaled by 8192.
  localparam tan_t TAN_TABLE [TAN_ENTRIES] = '{
    14'd0,    14'd201,  14'd402,  14'd604,  14'd806,  14'd1010, 14'd1215, 14'd1421,
    14'd1629, 14'd1839, 14'd2051, 14'd2267, 14'd2485, 14'd2706, 14'd2931, 14'd3160,
    14'd3393, 14'd3631, 14'd3874, 14'd4123, 14'd4378, 14'd4640, 14'd4910, 14'd5187,
    14'd5473, 14'd5769, 14'd6075, 14'd6393, 14'd6723, 14'd7066, 14'd7424, 14'd7799,
    14'd8192
  };

  // Octant information that travels alongside the division.
  typedef struct packed {
    logic [ANG_W-1:0] base;
    logic             sub;
    logic             zero;
  } side_t;

endpackage

@@ sv/baa_if.sv @@
// Valid/ready channel interfaces for the vector input and the angle result.
interface baa_in_if #(parameter int COORD_BITS = 18);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vec_x;
  logic signed [COORD_BITS-1:0] vec_y;

  modport source (output valid, output vec_x, output vec_y, input ready);
  modport sink   (input valid, input vec_x, input vec_y, output ready);
endinterface

interface baa_out_if import baa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ANG_W-1:0] angle;
  logic             zero_vector;

  modport source (output valid, output angle, output zero_vector, input ready);
  modport sink   (input valid, input angle, input zero_vector, output ready);
endinterface

@@ sv/baa_div_stage.sv @@
// One pipeline stage of the restoring divider, two quotient bits per stage.
module baa_div_stage import baa_pkg::*; #(
  parameter int MAG_W = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [MAG_W-1:0] in_rem,
  input  logic [MAG_W:0]   in_den2,
  input  logic [QUO_W-1:0] in_quo,
  input  side_t            in_side,
  output logic             out_valid,
  output logic [MAG_W-1:0] out_rem,
  output logic [MAG_W:0]   out_den2,
  output logic [QUO_W-1:0] out_quo,
  output side_t            out_side
);

  logic             valid_r;
  logic [MAG_W-1:0] rem_r, rem_nxt;
  logic [MAG_W:0]   den2_r;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  side_t            side_r;

  // Shift, compare against the doubled divisor and subtract, once per quotient bit.
  always_comb begin
    logic [MAG_W:0] t;
    rem_nxt = in_rem;
    quo_nxt = in_quo;
    t       = '0;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      t = {rem_nxt, 1'b0};
      if (t >= in_den2) begin
        rem_nxt = MAG_W'(t - in_den2);
        quo_nxt = {quo_nxt[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = t[MAG_W-1:0];
        quo_nxt = {quo_nxt[QUO_W-2:0], 1'b0};
      end
    end
  end

  // The valid bit is control state; the payload only loads on advance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      den2_r <= in_den2;
      quo_r  <= quo_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_den2  = den2_r;
  assign out_quo   = quo_r;
  assign out_side  = side_r;

endmodule

@@ sv/binary_angle_atan2.sv @@
// Top level: direction of a negated signed vector as an 8-bit binary angle.
//
// A vector (vec_x, vec_y) enters on the in_ch channel and one result
// (angle, zero_vector) leaves on the out_ch channel for every input transfer,
// in order. The angle is the direction of (-vec_x, -vec_y), 256 steps per turn.
// A zero vector gives angle 0 with zero_vector set.
// The input transfer loads the front-end stage (negate, fold into an octant),
// which is followed by seven divider stages, the tangent-table search stage
// and the output register.
// The 14-bit quotient comes from a restoring divider that resolves two bits
// per stage, so while out_ch does not stall an item can enter every cycle and
// throughput is one transfer per cycle.
// Synchronous active-low reset clears every valid bit; no item is in flight
// afterwards and in_ch.ready is high.
// When the receiver stalls, the result holds on out_ch. Stages behind it keep
// advancing into empty slots, so in_ch.ready only drops once all ten stages
// hold items.
module binary_angle_atan2 import baa_pkg::*; #(
  parameter int COORD_BITS = 18
) (
  input  logic       clk,
  input  logic       rst_n,
  baa_in_if.sink     in_ch,
  baa_out_if.source  out_ch
);

  localparam int MAG_W = COORD_BITS;

  // ---------------------------------------------------------------------------
  // Front end: negate, take magnitudes and classify the octant.
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS:0] xe, ye, xa_w, ya_w;
  logic [MAG_W-1:0]           ax, ay, num, den;
  logic                       xp, yp, gt;
  side_t                      side_nxt;

  always_comb begin
    xe   = {in_ch.vec_x[COORD_BITS-1], in_ch.vec_x};
    ye   = {in_ch.vec_y[COORD_BITS-1], in_ch.vec_y};
    xa_w = xe[COORD_BITS] ? -xe : xe;
    ya_w = ye[COORD_BITS] ? -ye : ye;
    ax   = xa_w[MAG_W-1:0];
    ay   = ya_w[MAG_W-1:0];
    // After negation a component is positive when the input was negative.
    xp   = in_ch.vec_x[COORD_BITS-1];
    yp   = in_ch.vec_y[COORD_BITS-1];
    gt   = ax > ay;
    num  = gt ? ay : ax;
    den  = gt ? ax : ay;
  end

  // Octant base angle and whether the table index is added or subtracted.
  always_comb begin
    side_nxt.zero = (ax == '0) && (ay == '0);
    case ({xp, yp, gt})
      3'b111: begin
        side_nxt.base = ANG_ZERO;
        side_nxt.sub  = 1'b0;
      end
      3'b110: begin
        side_nxt.base = ANG_QUARTER;
        side_nxt.sub  = 1'b1;
      end
      3'b101: begin
        side_nxt.base = ANG_ZERO;
        side_nxt.sub  = 1'b1;
      end
      3'b100: begin
        side_nxt.base = ANG_THREE_QUARTER;
        side_nxt.sub  = 1'b0;
      end
      3'b011: begin
        side_nxt.base = ANG_HALF;
        side_nxt.sub  = 1'b1;
      end
      3'b010: begin
        side_nxt.base = ANG_QUARTER;
        side_nxt.sub  = 1'b0;
      end
      3'b001: begin
        side_nxt.base = ANG_HALF;
        side_nxt.sub  = 1'b0;
      end
      default: begin
        side_nxt.base = ANG_THREE_QUARTER;
        side_nxt.sub  = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline registers and per-stage advance enables.
  // ---------------------------------------------------------------------------
  logic             s0_valid_r;
  logic [MAG_W-1:0] s0_rem_r;
  logic [MAG_W:0]   s0_den2_r;
  side_t            s0_side_r;

  logic             t_valid_r;
  logic [IDX_W-1:0] t_idx_r, t_idx_nxt;
  side_t            t_side_r;

  logic             o_valid_r;
  logic [ANG_W-1:0] o_angle_r, o_angle_nxt;
  logic             o_zero_r;

  logic                  en_s0, en_t, en_o;
  logic [DIV_STAGES-1:0] d_en;

  logic             d_valid [DIV_STAGES+1];
  logic [MAG_W-1:0] d_rem   [DIV_STAGES+1];
  logic [MAG_W:0]   d_den2  [DIV_STAGES+1];
  logic [QUO_W-1:0] d_quo   [DIV_STAGES+1];
  side_t            d_side  [DIV_STAGES+1];

  // A stage advances when it is empty or the stage after it advances.
  assign en_o  = !o_valid_r || out_ch.ready;
  assign en_t  = !t_valid_r || en_o;
  assign en_s0 = !s0_valid_r || d_en[0];

  assign in_ch.ready = en_s0;

  // Front-end register; the divisor is doubled so every divider step shifts alike.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en_s0) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s0) begin
      s0_rem_r  <= num;
      s0_den2_r <= {den, 1'b0};
      s0_side_r <= side_nxt;
    end
  end

  assign d_valid[0] = s0_valid_r;
  assign d_rem[0]   = s0_rem_r;
  assign d_den2[0]  = s0_den2_r;
  assign d_quo[0]   = '0;
  assign d_side[0]  = s0_side_r;

  // ---------------------------------------------------------------------------
  // Divider stages: quotient = smaller * 8192 / larger.
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    if (g == DIV_STAGES - 1) begin : g_last
      assign d_en[g] = !d_valid[g+1] || en_t;
    end else begin : g_mid
      assign d_en[g] = !d_valid[g+1] || d_en[g+1];
    end

    baa_div_stage #(.MAG_W(MAG_W)) u_div_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (d_en[g]),
      .in_valid  (d_valid[g]),
      .in_rem    (d_rem[g]),
      .in_den2   (d_den2[g]),
      .in_quo    (d_quo[g]),
      .in_side   (d_side[g]),
      .out_valid (d_valid[g+1]),
      .out_rem   (d_rem[g+1]),
      .out_den2  (d_den2[g+1]),
      .out_quo   (d_quo[g+1]),
      .out_side  (d_side[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Table search: first entry not below the quotient, else the last entry.
  // ---------------------------------------------------------------------------
  always_comb begin
    t_idx_nxt = IDX_W'(TAN_ENTRIES - 1);
    for (int i = TAN_ENTRIES - 2; i >= 0; i--) begin
      if (d_quo[DIV_STAGES] <= TAN_TABLE[i]) begin
        t_idx_nxt = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_valid_r <= 1'b0;
    end else if (en_t) begin
      t_valid_r <= d_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en_t) begin
      t_idx_r  <= t_idx_nxt;
      t_side_r <= d_side[DIV_STAGES];
    end
  end

  // ---------------------------------------------------------------------------
  // Map the index back to the full circle; the sum wraps modulo one turn.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (t_side_r.zero) begin
      o_angle_nxt = ANG_ZERO;
    end else if (t_side_r.sub) begin
      o_angle_nxt = t_side_r.base - ANG_W'(t_idx_r);
    end else begin
      o_angle_nxt = t_side_r.base + ANG_W'(t_idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (en_o) begin
      o_valid_r <= t_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      o_angle_r <= o_angle_nxt;
      o_zero_r  <= t_side_r.zero;
    end
  end

  assign out_ch.valid       = o_valid_r;
  assign out_ch.angle       = o_angle_r;
  assign out_ch.zero_vector = o_zero_r;

endmodule

@@ sv/baa_checker.sv @@
// Port-level checker for the binary-angle atan2 block, bound to the top level.
module baa_checker import baa_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ANG_W-1:0] angle,
  input logic             zero_vector
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic             in_xfer, out_xfer;
  logic [CNT_W-1:0] outstanding_r, outstanding_nxt;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Count of items accepted whose result has not yet been transferred.
  always_comb begin
    outstanding_nxt = outstanding_r;
    if (in_xfer && !out_xfer) begin
      outstanding_nxt = outstanding_r + CNT_W'(1);
    end else if (out_xfer && !in_xfer) begin
      outstanding_nxt = outstanding_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
    end else begin
      outstanding_r <= outstanding_nxt;
    end
  end

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(angle) && $stable(zero_vector))
    else $error("result changed while stalled");

  // A zero vector always reports angle zero.
  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_vector |-> angle == ANG_ZERO)
    else $error("zero vector with nonzero angle");

  // No result appears without an accepted item behind it.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> outstanding_r != '0)
    else $error("result without an accepted input");

  // The pipeline never holds more items than it has stages.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding_r <= CNT_W'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  // The input only back-pressures when the pipeline is full and a result waits on a stalled receiver.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready && outstanding_r == CNT_W'(PIPE_DEPTH))
    else $error("input stalled with room in the pipeline");

endmodule

bind binary_angle_atan2 baa_checker u_baa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .angle       (out_ch.angle),
  .zero_vector (out_ch.zero_vector)
);
